// File: sv/lltd_pkg.sv
// ----------------------------------------------------------------------------
// lltd_pkg
// Shared types and constants of the least-loaded task dispatcher.
// ----------------------------------------------------------------------------
package lltd_pkg;

  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ENTRY_W = 24;   // {priority[7:0], id[15:0]}
  localparam int LOAD_W  = 32;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_GET  = 2'd1,
    REQ_DONE = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  localparam logic CFG_PRIORITY_ORDER = 1'b0;
  localparam logic CFG_ACTIVE_QUEUES  = 1'b1;

  localparam logic [3:0] ACTIVE_RESET = 4'd8;

endpackage

// File: sv/lltd_ram.sv
// ----------------------------------------------------------------------------
// lltd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lltd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/least_loaded_task_dispatcher.sv
// ----------------------------------------------------------------------------
// least_loaded_task_dispatcher
// Dispatches tasks to the least-loaded worker queue; pops and retires tasks.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. busy stays high
//   until the request has finished; one result per request is shown for one
//   cycle with out_valid and must be sampled then (no back-pressure).
//   Add: a sequential scan over the active loads picks the queue (one load
//   per cycle), then in priority mode the queue is scanned for the insert
//   point and the tail entries are moved up one slot, all through the
//   single port of the entry RAM.
//   Get: one RAM read at the queue head, none on an empty queue.
//   Done and unused codes make no RAM access. out_valid is high in the
//   first cycle with busy low. Queues are circular buffers with a head
//   pointer per queue, so a get never moves entries.
//   cfg_we writes priority_order (index 0) or active_queues (index 1);
//   the user must write only while idle, the block does not enforce it.
//   Reset clears fills, heads and loads at once; no clearing pass.
// ----------------------------------------------------------------------------
module least_loaded_task_dispatcher #(
  parameter int NUM_QUEUES  = lltd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = lltd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_task_id,
  input  logic [15:0] in_task_weight,
  input  logic [7:0]  in_task_priority,
  input  logic [2:0]  in_worker_index,
  output logic        out_valid,
  output logic [15:0] out_task_id,
  output logic        out_task_found,
  output logic [2:0]  out_queue_chosen,
  output logic [31:0] out_load_outstanding,
  output logic [31:0] out_load_completed,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);

  localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW  = $clog2(NUM_QUEUES + 1);
  localparam int PW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = $clog2(QUEUE_DEPTH);
  localparam int MD  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW  = $clog2(MD);
  localparam int EW  = lltd_pkg::ENTRY_W;
  localparam int LW  = lltd_pkg::LOAD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SEARCH, S_CHECK, S_FIND, S_FIND_WT,
    S_SHIFT, S_SHIFT_WR, S_PLACE, S_GET_WT
  } state_t;

  state_t state_r;

  logic          prio_r;
  logic [3:0]    active_r;

  logic [1:0]    req_r;
  logic [15:0]   id_r;
  logic [15:0]   wt_r;
  logic [7:0]    pri_r;
  logic [2:0]    wk_r;
  logic          wk_oob_r;

  logic [QIW-1:0] q_r;
  logic [CW-1:0]  scan_r;
  logic [QIW-1:0] best_r;
  logic [LW-1:0]  best_ld_r;
  logic [PW-1:0]  pos_r;
  logic [PW-1:0]  i_r;

  logic [PW-1:0] fill_r  [NUM_QUEUES];
  logic [SW-1:0] head_r  [NUM_QUEUES];
  logic [LW-1:0] outl_r  [NUM_QUEUES];
  logic [LW-1:0] cmpl_r  [NUM_QUEUES];

  logic          out_valid_r;
  logic [15:0]   out_id_r;
  logic          out_found_r;
  logic [2:0]    out_q_r;
  logic [LW-1:0] out_outl_r;
  logic [LW-1:0] out_cmpl_r;
  logic [1:0]    out_st_r;

  // shared slot/address unit
  logic [QIW-1:0] ld_idx;
  logic [LW-1:0]  ld_rd;
  logic [PW-1:0]  fill_q;
  logic [SW-1:0]  head_q;
  logic [PW-1:0]  mem_idx;
  logic [PW:0]    slot_sum;
  logic [SW-1:0]  slot;
  logic [AW-1:0]  mem_addr;
  logic           mem_we;
  logic [EW-1:0]  mem_wdata;
  logic [EW-1:0]  mem_rdata;
  logic [CW-1:0]  n_act;
  logic [LW:0]    add_sum;
  logic [LW:0]    cmp_sum;
  logic [SW:0]    head_inc;

  assign ld_idx = (state_r == S_SEARCH) ? scan_r[QIW-1:0] : q_r;
  assign ld_rd  = outl_r[ld_idx];
  assign fill_q = fill_r[q_r];
  assign head_q = head_r[q_r];

  always_comb begin
    if (active_r == 4'd0) begin
      n_act = CW'(1);
    end else if (32'(active_r) > NUM_QUEUES) begin
      n_act = CW'(NUM_QUEUES);
    end else begin
      n_act = CW'(active_r);
    end
  end

  always_comb begin
    case (state_r)
      S_FIND, S_PLACE: mem_idx = pos_r;
      S_SHIFT:         mem_idx = i_r - PW'(1);
      S_SHIFT_WR:      mem_idx = i_r;
      default:         mem_idx = '0;
    endcase
    slot_sum = (PW+1)'(head_q) + (PW+1)'(mem_idx);
    if (32'(slot_sum) >= QUEUE_DEPTH) begin
      slot = SW'(32'(slot_sum) - QUEUE_DEPTH);
    end else begin
      slot = SW'(slot_sum);
    end
    mem_addr = AW'(32'(q_r) * QUEUE_DEPTH + 32'(slot));
  end

  assign mem_we    = (state_r == S_SHIFT_WR) || (state_r == S_PLACE);
  assign mem_wdata = (state_r == S_PLACE) ? {pri_r, id_r} : mem_rdata;

  assign add_sum  = (LW+1)'(outl_r[q_r]) + (LW+1)'(wt_r);
  assign cmp_sum  = (LW+1)'(cmpl_r[q_r]) + (LW+1)'(wt_r);
  assign head_inc = (SW+1)'(head_q) + (SW+1)'(1);

  lltd_ram #(
    .WIDTH (EW),
    .DEPTH (MD)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prio_r      <= 1'b0;
      active_r    <= lltd_pkg::ACTIVE_RESET;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_QUEUES; k++) begin
        fill_r[k] <= '0;
        head_r[k] <= '0;
        outl_r[k] <= '0;
        cmpl_r[k] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          lltd_pkg::CFG_PRIORITY_ORDER: prio_r   <= cfg_wdata[0];
          lltd_pkg::CFG_ACTIVE_QUEUES:  active_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r    <= in_req_type;
            id_r     <= in_task_id;
            wt_r     <= in_task_weight;
            pri_r    <= in_task_priority;
            wk_r     <= in_worker_index;
            wk_oob_r <= (32'(in_worker_index) >= NUM_QUEUES);
            q_r      <= QIW'(32'(in_worker_index));
            state_r  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          out_id_r    <= '0;
          out_found_r <= 1'b0;
          out_q_r     <= wk_r;
          out_outl_r  <= '0;
          out_cmpl_r  <= '0;
          out_st_r    <= lltd_pkg::ST_OK;
          case (req_r)
            lltd_pkg::REQ_ADD: begin
              scan_r  <= '0;
              state_r <= S_SEARCH;
            end
            lltd_pkg::REQ_GET: begin
              if (wk_oob_r || fill_q == '0) begin
                out_st_r <= lltd_pkg::ST_EMPTY;
                if (!wk_oob_r) begin
                  out_outl_r <= outl_r[q_r];
                  out_cmpl_r <= cmpl_r[q_r];
                end
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                state_r <= S_GET_WT;   // head read issued this cycle
              end
            end
            lltd_pkg::REQ_DONE: begin
              if (!wk_oob_r) begin
                if (cmp_sum[LW]) begin
                  cmpl_r[q_r] <= '1;
                  out_cmpl_r  <= '1;
                  out_st_r    <= lltd_pkg::ST_SAT;
                end else begin
                  cmpl_r[q_r] <= cmp_sum[LW-1:0];
                  out_cmpl_r  <= cmp_sum[LW-1:0];
                end
                if (outl_r[q_r] < LW'(wt_r)) begin
                  outl_r[q_r] <= '0;
                  out_outl_r  <= '0;
                  out_st_r    <= lltd_pkg::ST_SAT;
                end else begin
                  outl_r[q_r] <= outl_r[q_r] - LW'(wt_r);
                  out_outl_r  <= outl_r[q_r] - LW'(wt_r);
                end
              end
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            default: begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_SEARCH: begin
          if (scan_r < n_act) begin
            if (scan_r == '0 || ld_rd < best_ld_r) begin
              best_r    <= scan_r[QIW-1:0];
              best_ld_r <= ld_rd;
            end
            scan_r <= scan_r + CW'(1);
          end else begin
            q_r     <= best_r;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          out_q_r <= 3'(32'(q_r));
          if (32'(fill_q) >= QUEUE_DEPTH) begin
            out_outl_r  <= outl_r[q_r];
            out_cmpl_r  <= cmpl_r[q_r];
            out_st_r    <= lltd_pkg::ST_FULL;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (prio_r) begin
            pos_r   <= '0;
            state_r <= S_FIND;
          end else begin
            pos_r   <= fill_q;
            state_r <= S_PLACE;
          end
        end
        S_FIND: begin
          if (pos_r < fill_q) begin
            state_r <= S_FIND_WT;
          end else begin
            i_r     <= fill_q;
            state_r <= S_SHIFT;
          end
        end
        S_FIND_WT: begin
          if (mem_rdata[23:16] <= pri_r) begin
            i_r     <= fill_q;
            state_r <= S_SHIFT;
          end else begin
            pos_r   <= pos_r + PW'(1);
            state_r <= S_FIND;
          end
        end
        S_SHIFT: begin
          // move entry i-1 up to slot i, tail first
          if (i_r > pos_r) begin
            state_r <= S_SHIFT_WR;
          end else begin
            state_r <= S_PLACE;
          end
        end
        S_SHIFT_WR: begin
          i_r     <= i_r - PW'(1);
          state_r <= S_SHIFT;
        end
        S_PLACE: begin
          fill_r[q_r] <= fill_q + PW'(1);
          out_cmpl_r  <= cmpl_r[q_r];
          if (add_sum[LW]) begin
            outl_r[q_r] <= '1;
            out_outl_r  <= '1;
            out_st_r    <= lltd_pkg::ST_SAT;
          end else begin
            outl_r[q_r] <= add_sum[LW-1:0];
            out_outl_r  <= add_sum[LW-1:0];
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_GET_WT: begin
          out_id_r    <= mem_rdata[15:0];
          out_found_r <= 1'b1;
          out_outl_r  <= outl_r[q_r];
          out_cmpl_r  <= cmpl_r[q_r];
          fill_r[q_r] <= fill_q - PW'(1);
          if (32'(head_inc) >= QUEUE_DEPTH) begin
            head_r[q_r] <= '0;
          end else begin
            head_r[q_r] <= head_inc[SW-1:0];
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_task_id          = out_id_r;
  assign out_task_found       = out_found_r;
  assign out_queue_chosen     = out_q_r;
  assign out_load_outstanding = out_outl_r;
  assign out_load_completed   = out_cmpl_r;
  assign out_status           = out_st_r;

endmodule
